/* design/binary_gcd_unsigned_macros.svh */
// assertion helpers used by the checker file
`ifndef BINARY_GCD_UNSIGNED_MACROS_SVH
`define BINARY_GCD_UNSIGNED_MACROS_SVH

// property sampled on the block clock, quiet while in reset
`define BGCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define BGCD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* design/bgcd_pkg.sv */
`timescale 1ns / 1ps

package bgcd_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int TWOS_WIDTH = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  // one-hot controller states
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_STRIP  = 5'b00010,
    S_ODDA   = 5'b00100,
    S_LOOP   = 5'b01000,
    S_FINISH = 5'b10000
  } bgcd_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture operands, clear the power-of-two count
    logic strip;     // halve both, count one common factor of two
    logic halve_a;
    logic halve_b;
    logic sub_step;  // b <= |a - b|, a <= b
    logic out_load;  // capture the final result
  } bgcd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic a_lsb;
    logic b_lsb;
  } bgcd_stat_t;

endpackage

/* design/bgcd_ctrl.sv */
`timescale 1ns / 1ps

module bgcd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  bgcd_pkg::bgcd_stat_t stat_i,
  output bgcd_pkg::bgcd_cmd_t  cmd_o
);
  import bgcd_pkg::*;

  bgcd_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_STRIP;
        end
      end
      S_STRIP: begin
        if (stat_i.a_zero || stat_i.b_zero) begin
          state_d = S_FINISH;
        end else if (!stat_i.a_lsb && !stat_i.b_lsb) begin
          cmd_o.strip = 1'b1;
        end else begin
          state_d = S_ODDA;
        end
      end
      S_ODDA: begin
        if (!stat_i.a_lsb) begin
          cmd_o.halve_a = 1'b1;
        end else begin
          state_d = S_LOOP;
        end
      end
      S_LOOP: begin
        if (stat_i.b_zero) begin
          state_d = S_FINISH;
        end else if (!stat_i.b_lsb) begin
          cmd_o.halve_b = 1'b1;
        end else begin
          cmd_o.sub_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* design/bgcd_dp.sv */
`timescale 1ns / 1ps

module bgcd_dp (
  input  logic                            clk_i,
  input  logic [bgcd_pkg::DATA_WIDTH-1:0] operand_a_i,
  input  logic [bgcd_pkg::DATA_WIDTH-1:0] operand_b_i,
  input  bgcd_pkg::bgcd_cmd_t             cmd_i,
  output bgcd_pkg::bgcd_stat_t            stat_o,
  output logic [bgcd_pkg::DATA_WIDTH-1:0] gcd_value_o
);
  import bgcd_pkg::*;

  logic [DATA_WIDTH-1:0] a_q, a_d;
  logic [DATA_WIDTH-1:0] b_q, b_d;
  logic [TWOS_WIDTH-1:0] twos_q, twos_d;
  logic [DATA_WIDTH-1:0] gcd_q;
  logic [DATA_WIDTH:0]   a_minus_b;
  logic [DATA_WIDTH-1:0] b_minus_a;
  logic [DATA_WIDTH-1:0] abs_diff;
  logic [DATA_WIDTH-1:0] result;

  assign stat_o.a_zero = (a_q == '0);
  assign stat_o.b_zero = (b_q == '0);
  assign stat_o.a_lsb  = a_q[0];
  assign stat_o.b_lsb  = b_q[0];

  // borrow out of a - b picks the larger operand
  assign a_minus_b = {1'b0, a_q} - {1'b0, b_q};
  assign b_minus_a = b_q - a_q;
  assign abs_diff  = a_minus_b[DATA_WIDTH] ? b_minus_a : a_minus_b[DATA_WIDTH-1:0];

  // one side is zero at the end, so the or gives the survivor
  assign result = (a_q | b_q) << twos_q;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    twos_d = twos_q;
    if (cmd_i.load) begin
      a_d    = operand_a_i;
      b_d    = operand_b_i;
      twos_d = '0;
    end else if (cmd_i.strip) begin
      a_d    = a_q >> 1;
      b_d    = b_q >> 1;
      twos_d = twos_q + TWOS_WIDTH'(1);
    end else if (cmd_i.halve_a) begin
      a_d = a_q >> 1;
    end else if (cmd_i.halve_b) begin
      b_d = b_q >> 1;
    end else if (cmd_i.sub_step) begin
      a_d = b_q;
      b_d = abs_diff;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    twos_q <= twos_d;
    if (cmd_i.out_load) begin
      gcd_q <= result;
    end
  end

  assign gcd_value_o = gcd_q;

endmodule

/* design/binary_gcd_unsigned.sv */
`timescale 1ns / 1ps

// binary (stein) gcd of two unsigned DATA_WIDTH-bit operands
// input channel: in_valid_i / in_stall_o with operand_a_i, operand_b_i;
//   a beat is taken when valid is high and stall is low
// output channel: out_valid_o / out_stall_i with gcd_value_o, one beat per input
// one item at a time: in_stall_o is high from the cycle after a beat is taken
//   until the result has moved into the output register
// sequence: one shift or subtract step at a time on the single shared
//   shift/subtract datapath; a zero operand goes straight to the finish,
//   otherwise common twos, then making a odd, then the halve-b / subtract loop
// overlap: the next beat can be taken while the
//   previous result still sits in the output register
// receiver stall: the output register holds value and valid; a finished
//   result waits in the controller until that register is free
// reset (rst_ni low, asynchronous): controller returns to idle and the
//   output valid clears; operand registers are not reset
module binary_gcd_unsigned (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bgcd_pkg::DATA_WIDTH-1:0] operand_a_i,
  input  logic [bgcd_pkg::DATA_WIDTH-1:0] operand_b_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bgcd_pkg::DATA_WIDTH-1:0] gcd_value_o
);
  import bgcd_pkg::*;

  // command and status between the sequencer and the datapath
  bgcd_cmd_t  cmd;
  bgcd_stat_t stat;

  // sequencer: strip common twos, make a odd, loop until b is zero
  bgcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // operand registers, subtractors and result register
  bgcd_dp u_dp (
    .clk_i       (clk_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .gcd_value_o (gcd_value_o)
  );

endmodule

/* design/bgcd_checker.sv */
`timescale 1ns / 1ps

`include "binary_gcd_unsigned_macros.svh"

module bgcd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [bgcd_pkg::DATA_WIDTH-1:0] gcd_value_o
);
  import bgcd_pkg::*;

  logic in_beat;

  assign in_beat    = in_valid_i && !in_stall_o;

  // a stalled result beat keeps valid and value
  `BGCD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "out valid dropped")
  `BGCD_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(gcd_value_o),
                    "stalled result changed")
  // one item at a time: busy right after taking a beat
  `BGCD_ASSERT_NEXT(a_busy_after_beat, in_beat, in_stall_o, "input open while busy")
  // a new result only appears out of a busy period
  `BGCD_ASSERT(a_result_from_busy, $rose(out_valid_o) |-> $past(in_stall_o),
               "result without work")

endmodule

bind binary_gcd_unsigned bgcd_checker u_bgcd_checker (.*);

/* test/gcd_result_checker.sv */
`timescale 1ns / 1ps

module gcd_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [bgcd_pkg::DATA_WIDTH-1:0] operand_a_i,
  input  logic [bgcd_pkg::DATA_WIDTH-1:0] operand_b_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [bgcd_pkg::DATA_WIDTH-1:0] gcd_value_i,
  output int unsigned                     error_count_o,
  output int unsigned                     pending_count_o
);

  localparam int DW = bgcd_pkg::DATA_WIDTH;

  logic [DW-1:0] gcd_expected_q[$];

  initial error_count_o = 0;

  assign pending_count_o = gcd_expected_q.size();

  function automatic logic [DW-1:0] binary_gcd_of(logic [DW-1:0] a, logic [DW-1:0] b);
    int unsigned   twos;
    logic [DW-1:0] keep;
    twos = 0;
    if (a == '0) return b;
    if (b == '0) return a;
    while (a[0] == 1'b0 && b[0] == 1'b0) begin
      a = a >> 1;
      b = b >> 1;
      twos++;
    end
    while (a[0] == 1'b0) a = a >> 1;
    while (b != '0) begin
      while (b[0] == 1'b0) b = b >> 1;
      keep = b;
      b    = (a > b) ? a - b : b - a;
      a    = keep;
    end
    return a << twos;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count_o++;
  endtask

  // signals are read before this edge's updates land
  always @(posedge clk_i) begin
    logic [DW-1:0] want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        gcd_expected_q.push_back(binary_gcd_of(operand_a_i, operand_b_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (gcd_expected_q.size() == 0) begin
          report_mismatch($sformatf("result beat %0h with none pending", gcd_value_i));
        end else begin
          want = gcd_expected_q.pop_front();
          if (gcd_value_i !== want) begin
            report_mismatch($sformatf("gcd_value %0h, predicted %0h", gcd_value_i, want));
          end
        end
      end
    end
  end

endmodule

/* test/tb_binary_gcd_unsigned.sv */
`timescale 1ns / 1ps

module tb_binary_gcd_unsigned;

  localparam int          DW          = bgcd_pkg::DATA_WIDTH;
  // drain well past the worst case
  localparam int          DRAIN_TICKS = 8 * DW;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          LONG_HOLD   = 400;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_stall_o;
  logic [DW-1:0] operand_a_i = '0;
  logic [DW-1:0] operand_b_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic [DW-1:0] gcd_value_o;

  int unsigned error_count;
  int unsigned pending_count;
  int unsigned cycle_count = 0;

  // idle and stall odds in percent, changed per phase
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  // a bump of hold_req asks the receiver for one long hold-off
  int unsigned hold_req  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  binary_gcd_unsigned dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .gcd_value_o (gcd_value_o)
  );

  gcd_result_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .operand_a_i     (operand_a_i),
    .operand_b_i     (operand_b_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .gcd_value_i     (gcd_value_o),
    .error_count_o   (error_count),
    .pending_count_o (pending_count)
  );

  // 10 ns clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: generous bound over the slowest legal run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request that is counted
  // down here so the sender keeps pushing and the block backs up to its input
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= LONG_HOLD;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // offer one beat, with random idle cycles ahead of it, and wait until taken;
  // returns right at the accepting edge so the next call drives only once
  task automatic send_operands(input logic [DW-1:0] a, input logic [DW-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // operand pairs of several shapes: plain random, shared factor,
  // many trailing zeros, small values, zero operands, equal or related values
  task automatic send_random_pair();
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic [DW-1:0] f;
    case ($urandom_range(9))
      0, 1, 2: begin
        a = $urandom;
        b = $urandom;
      end
      3, 4, 5: begin
        // common factor so the result is more than a small odd number
        f = ($urandom >> $urandom_range(8, 31)) | 1;
        f = f << $urandom_range(0, 6);
        a = f * ($urandom >> $urandom_range(12, 31));
        b = f * ($urandom >> $urandom_range(12, 31));
      end
      6: begin
        // deep common power of two, exercises the strip phase
        a = $urandom << $urandom_range(0, DW - 1);
        b = $urandom << $urandom_range(0, DW - 1);
      end
      7: begin
        a = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
      end
      8: begin
        // a zero on either side, now and then on both, now and then equal values
        a = $urandom;
        b = '0;
        case ($urandom_range(3))
          0:       b = a;
          1:       a = '0;
          default: ;
        endcase
        if ($urandom_range(1)) begin
          f = a;
          a = b;
          b = f;
        end
      end
      default: begin
        a = $urandom;
        case ($urandom_range(2))
          0:       b = a;
          1:       b = a + $urandom_range(0, 7) - 3;
          default: b = a * $urandom_range(1, 9);
        endcase
      end
    endcase
    send_operands(a, b);
  endtask

  task automatic send_random_run(input int n);
    repeat (n) send_random_pair();
  endtask

  initial begin
    // reset held from the start, released once
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero operands, field extremes, deep shared twos, equal and
    // coprime operands, the longest subtract loops
    send_operands('0, '0);
    send_operands('0, 32'd12);
    send_operands(32'd12, '0);
    send_operands('0, '1);
    send_operands('1, '0);
    send_operands(32'h8000_0000, '0);
    send_operands('1, '1);
    send_operands('1, 32'd1);
    send_operands(32'd1, '1);
    send_operands(32'd1, 32'd1);
    send_operands('1, 32'hFFFF_FFFE);
    send_operands(32'h8000_0000, 32'h8000_0000);
    send_operands(32'h8000_0000, 32'h4000_0000);
    send_operands(32'hC000_0000, 32'h4000_0000);
    send_operands(32'h8000_0000, 32'd1);
    send_operands(32'd1, 32'h8000_0000);
    send_operands(32'hFFFF_FFFB, 32'hFFFF_FFEF);
    send_operands(32'd48, 32'd18);
    send_operands(32'd18, 32'd48);
    send_operands(32'hAAAA_AAAA, 32'h5555_5555);
    send_operands(32'hB504_F334, 32'h9E37_79B9);
    send_operands(32'h7FFF_FFFF, 32'h8000_0000);
    send_operands(32'hFFFF_FFFF, 32'h0001_0001);

    // no idling on either side
    send_random_run(400);

    // sender idle odds at 67 percent
    idle_pct = 67;
    send_random_run(400);

    // receiver stall odds at 67 percent
    idle_pct  = 0;
    stall_pct <= 67;
    send_random_run(400);

    // light idling on both sides
    idle_pct  = 13;
    stall_pct <= 13;
    send_random_run(400);

    // long receiver hold-off while the sender keeps offering back to back
    idle_pct  = 0;
    stall_pct <= 0;
    hold_req  <= hold_req + 1;
    send_random_run(25);

    // back to light idling for the tail
    idle_pct  = 13;
    stall_pct <= 13;
    send_random_run(125);
    in_valid_i <= 1'b0;

    // drain everything pending, then give stray beats a chance to show up
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_TICKS) @(posedge clk_i);

    if (error_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* binary_gcd_unsigned.f */
+incdir+design
design/bgcd_pkg.sv
design/bgcd_ctrl.sv
design/bgcd_dp.sv
design/binary_gcd_unsigned.sv
design/bgcd_checker.sv
test/gcd_result_checker.sv
test/tb_binary_gcd_unsigned.sv
